// ===== sv/coincidence_window_event_builder_macros.svh =====
// Assertion macros used by the event builder sequencer.
`ifndef COINCIDENCE_WINDOW_EVENT_BUILDER_MACROS_SVH
`define COINCIDENCE_WINDOW_EVENT_BUILDER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CWEB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CWEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cweb_pkg.sv =====
// Types, constants and register codes of the coincidence window event builder.
package cweb_pkg;

   // Sizes of the block.
   localparam int NUM_SLOTS     = 6;
   localparam int TIME_BITS     = 64;
   localparam int ENERGY_BITS   = 16;
   localparam int CHAN_BITS     = 4;
   localparam int COUNT_BITS    = 4;
   localparam int SLOT_IDX_BITS = 3;
   localparam int SLOT_AW       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // Configuration register file.
   localparam int WINDOW_BITS    = 31;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 31;
   localparam int NUM_CHAN_REGS  = 6;
   localparam int CHAN_RESET_BASE = 8;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(5000000);
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOT0  = CSR_IDX_BITS'(1);

   // Hit counter saturation value.
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Input action codes.
   localparam logic ACT_HIT   = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // Input transaction payload.
   typedef struct packed {
      logic                   action;
      logic [TIME_BITS-1:0]   hit_time;
      logic [CHAN_BITS-1:0]   hit_channel;
      logic [ENERGY_BITS-1:0] long_energy;
      logic [ENERGY_BITS-1:0] short_energy;
   } req_type;

   // Result transaction payload: one slot record.
   typedef struct packed {
      logic [SLOT_IDX_BITS-1:0] slot_index;
      logic [COUNT_BITS-1:0]    slot_hits;
      logic [TIME_BITS-1:0]     slot_time;
      logic [ENERGY_BITS-1:0]   slot_long;
      logic [ENERGY_BITS-1:0]   slot_short;
      logic [TIME_BITS-1:0]     event_start;
      logic                     last_record;
   } rsp_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [WINDOW_BITS-1:0]              window;
      logic [NUM_SLOTS-1:0][CHAN_BITS-1:0] slot_chan;
   } cfg_type;

   // One entry of the slot memory.
   typedef struct packed {
      logic [COUNT_BITS-1:0]  count;
      logic [TIME_BITS-1:0]   stamp;
      logic [ENERGY_BITS-1:0] long_e;
      logic [ENERGY_BITS-1:0] short_e;
   } slot_entry_type;

   // Access request to the slot memory.
   typedef struct packed {
      logic               wr_en;
      logic [SLOT_AW-1:0] wr_addr;
      slot_entry_type     wr_data;
      logic               rd_en;
      logic [SLOT_AW-1:0] rd_addr;
   } ram_ctl_type;

   // Load request to the result register.
   typedef struct packed {
      logic    load;
      rsp_type data;
   } rsp_load_type;

endpackage

// ===== sv/cweb_csr.sv =====
// Configuration registers: coincidence window and slot channel map.
module cweb_csr
   import cweb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   logic [WINDOW_BITS-1:0]              window_ff;
   logic [NUM_SLOTS-1:0][CHAN_BITS-1:0] chan_ff;

   // Register writes; slots without a register keep their reset channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            chan_ff[s] <= CHAN_BITS'(CHAN_RESET_BASE + s);
         end
      end else if (csr_wen) begin
         if (csr_index == CSR_WINDOW) begin
            window_ff <= csr_wdata[WINDOW_BITS-1:0];
         end
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (s < NUM_CHAN_REGS && csr_index == CSR_IDX_BITS'(CSR_SLOT0 + s)) begin
               chan_ff[s] <= csr_wdata[CHAN_BITS-1:0];
            end
         end
      end
   end

   assign cfg.window    = window_ff;
   assign cfg.slot_chan = chan_ff;

endmodule

// ===== sv/cweb_slot_ram.sv =====
// Slot memory: one entry per slot, one access per cycle, registered read data.
module cweb_slot_ram
   import cweb_pkg::*;
(
   input  logic           clock,
   input  ram_ctl_type    ram_ctl,
   output slot_entry_type rd_data
);

   slot_entry_type mem_ff [NUM_SLOTS];
   slot_entry_type rd_data_ff;

   // Synchronous write and read; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (ram_ctl.wr_en) begin
         mem_ff[ram_ctl.wr_addr] <= ram_ctl.wr_data;
      end
      if (ram_ctl.rd_en) begin
         rd_data_ff <= mem_ff[ram_ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cweb_seq.sv =====
// Event sequencer: window test, slot read-modify-write and record readout.
`include "coincidence_window_event_builder_macros.svh"
module cweb_seq
   import cweb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   input  cfg_type        cfg,
   input  logic           out_free,
   output ram_ctl_type    ram_ctl,
   input  slot_entry_type ram_rd_data,
   output rsp_load_type   rsp_load
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_EMIT_RD,
      ST_EMIT_LD
   } seq_state_type;

   seq_state_type          state_ff, state_in;
   logic                   event_open_ff, event_open_in;
   logic [TIME_BITS-1:0]   start_time_ff, start_time_in;
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;
   logic [NUM_SLOTS-1:0]   mask_ff, mask_in;
   logic [SLOT_AW-1:0]     slot_ff, slot_in;
   logic                   reopen_ff, reopen_in;
   req_type                hit_ff, hit_in;

   // Lowest set bit of a slot mask.
   function automatic logic [SLOT_AW-1:0] first_set(input logic [NUM_SLOTS-1:0] m);
      logic [SLOT_AW-1:0] idx;
      idx = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (m[s]) idx = SLOT_AW'(s);
      end
      return idx;
   endfunction

   // Next-state logic and memory and output requests.
   always_comb begin
      logic [TIME_BITS-1:0]   diff;
      logic                   in_window;
      logic [NUM_SLOTS-1:0]   match;
      logic [SLOT_AW-1:0]     pick;
      slot_entry_type         cur;
      logic                   last;

      state_in      = state_ff;
      event_open_in = event_open_ff;
      start_time_in = start_time_ff;
      valid_in      = valid_ff;
      mask_in       = mask_ff;
      slot_in       = slot_ff;
      reopen_in     = reopen_ff;
      hit_in        = hit_ff;
      ram_ctl       = '0;
      rsp_load      = '0;
      req_ready     = 1'b0;

      // Wrapping time since the event start, against the window.
      diff      = req_data.hit_time - start_time_ff;
      in_window = diff < TIME_BITS'(cfg.window);

      for (int s = 0; s < NUM_SLOTS; s++) begin
         match[s] = cfg.slot_chan[s] == req_data.hit_channel;
      end

      pick = first_set(mask_ff);
      // Entries not written in this event read as zero.
      cur  = valid_ff[slot_ff] ? ram_rd_data : '0;
      last = slot_ff == SLOT_AW'(NUM_SLOTS - 1);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               hit_in  = req_data;
               mask_in = match;
               slot_in = '0;
               if (req_data.action == ACT_FLUSH) begin
                  if (event_open_ff) begin
                     reopen_in = 1'b0;
                     state_in  = ST_EMIT_RD;
                  end
               end else if (!event_open_ff) begin
                  event_open_in = 1'b1;
                  start_time_in = req_data.hit_time;
                  state_in      = ST_UPD_RD;
               end else if (in_window) begin
                  state_in = ST_UPD_RD;
               end else begin
                  reopen_in = 1'b1;
                  state_in  = ST_EMIT_RD;
               end
            end
         end

         // Read the next slot that the hit maps to.
         ST_UPD_RD: begin
            if (mask_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ram_ctl.rd_en = 1'b1;
               ram_ctl.rd_addr = pick;
               slot_in = pick;
               mask_in = mask_ff & ~(NUM_SLOTS'(1) << pick);
               state_in = ST_UPD_WR;
            end
         end

         // Write the slot back with the new hit and a saturating count.
         ST_UPD_WR: begin
            ram_ctl.wr_en           = 1'b1;
            ram_ctl.wr_addr         = slot_ff;
            ram_ctl.wr_data.count   = (cur.count == COUNT_MAX) ? COUNT_MAX
                                    : COUNT_BITS'(cur.count + 1'b1);
            ram_ctl.wr_data.stamp   = hit_ff.hit_time;
            ram_ctl.wr_data.long_e  = hit_ff.long_energy;
            ram_ctl.wr_data.short_e = hit_ff.short_energy;
            valid_in[slot_ff]       = 1'b1;
            state_in = (mask_ff == '0) ? ST_IDLE : ST_UPD_RD;
         end

         ST_EMIT_RD: begin
            ram_ctl.rd_en   = 1'b1;
            ram_ctl.rd_addr = slot_ff;
            state_in        = ST_EMIT_LD;
         end

         // Hand the slot record to the result register once it is free.
         ST_EMIT_LD: begin
            if (out_free) begin
               rsp_load.load             = 1'b1;
               rsp_load.data.slot_index  = SLOT_IDX_BITS'(slot_ff);
               rsp_load.data.slot_hits   = cur.count;
               rsp_load.data.slot_time   = cur.stamp;
               rsp_load.data.slot_long   = cur.long_e;
               rsp_load.data.slot_short  = cur.short_e;
               rsp_load.data.event_start = start_time_ff;
               rsp_load.data.last_record = last;
               if (last) begin
                  valid_in = '0;
                  if (reopen_ff) begin
                     start_time_in = hit_ff.hit_time;
                     state_in      = ST_UPD_RD;
                  end else begin
                     event_open_in = 1'b0;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  slot_in  = SLOT_AW'(slot_ff + 1'b1);
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and event registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         event_open_ff <= 1'b0;
         start_time_ff <= '0;
         valid_ff      <= '0;
         mask_ff       <= '0;
         slot_ff       <= '0;
         reopen_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         event_open_ff <= event_open_in;
         start_time_ff <= start_time_in;
         valid_ff      <= valid_in;
         mask_ff       <= mask_in;
         slot_ff       <= slot_in;
         reopen_ff     <= reopen_in;
      end
      hit_ff <= hit_in;
   end

   // The single memory port is never asked for a read and a write at once.
   `CWEB_ASSERT_NOW(a_one_access, clock, reset, ram_ctl.wr_en, !ram_ctl.rd_en, "slot memory read and write in the same cycle")
   // A record is only loaded when the result register can take it.
   `CWEB_ASSERT_NOW(a_load_free, clock, reset, rsp_load.load, out_free, "record loaded into a busy result register")
   // The final record of an event clears all slots.
   `CWEB_ASSERT_NEXT(a_last_clears, clock, reset, rsp_load.load && rsp_load.data.last_record, valid_ff == '0, "slots not cleared after the final record")
   // Readout only ever runs on an open event.
   `CWEB_ASSERT_NOW(a_emit_open, clock, reset, state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD, event_open_ff, "readout without an open event")

endmodule

// ===== sv/coincidence_window_event_builder.sv =====
// Coincidence window event builder: top level with the result register.
//
// Hits arrive in timestamp order and are grouped into events by a window
// measured from the hit that opened the event. Six slot entries live in a
// single-port slot memory with registered read data, and every slot
// update is a read followed by a write on that port. A hit that joins or
// opens an event updates each slot mapped to its channel in turn, and a
// hit on an unmapped channel updates none. A closing hit or a flush reads
// out the six slot records in turn, waiting while the result side stalls,
// and a closing hit then takes its own slot update. A flush with no open
// event is accepted and reads out nothing. A finished record waits in the
// result register while the next input transaction is taken.
// Configuration writes take effect on the next cycle.
module coincidence_window_event_builder
   import cweb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_wen,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type        cfg;
   ram_ctl_type    ram_ctl;
   slot_entry_type ram_rd_data;
   rsp_load_type   rsp_load;
   logic           out_free;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   cweb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cweb_slot_ram u_slot_ram (
      .clock   (clock),
      .ram_ctl (ram_ctl),
      .rd_data (ram_rd_data)
   );

   cweb_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .cfg         (cfg),
      .out_free    (out_free),
      .ram_ctl     (ram_ctl),
      .ram_rd_data (ram_rd_data),
      .rsp_load    (rsp_load)
   );

   // The result register is free when empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Result register next value.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load.load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_load.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
